[hw/rtl/vjb_pkg.sv]
// shared types and codes for the voice jitter buffer
// used by vjb_core and voice_jitter_buffer; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package vjb_pkg;

  localparam int SEQ_W = 16;
  localparam int TAG_W = 16;
  localparam int CNT_OUT_W = 4;

  localparam logic MODE_SUBMIT = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  localparam logic [1:0] ST_STORED = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_PLAYED = 2'd2;
  localparam logic [1:0] ST_LOST   = 2'd3;

  localparam logic [1:0] REG_TARGET = 2'd0;
  localparam logic [1:0] REG_CAP    = 2'd1;
  localparam logic [1:0] REG_MUTED  = 2'd2;

  localparam logic [3:0] TARGET_RST = 4'd3;
  localparam logic [3:0] CAP_RST    = 4'd8;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [TAG_W-1:0] tag;
    logic             ok;
  } slot_t;

  typedef struct packed {
    logic             mode;
    logic [SEQ_W-1:0] seq;
    logic [TAG_W-1:0] tag;
    logic             ok;
  } item_t;

  typedef struct packed {
    logic [3:0] target;
    logic [3:0] cap;
    logic       muted;
  } cfg_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [CNT_OUT_W-1:0] dropped;
    logic [SEQ_W-1:0]     seq;
    logic [TAG_W-1:0]     tag;
    logic                 ok;
    logic [CNT_OUT_W-1:0] fill;
    logic                 primed;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/vjb_core.sv]
// frame list, fill count, priming and expected sequence of the jitter buffer
// one item per step; depends on vjb_pkg
`timescale 1ns / 1ps
`default_nettype none

module vjb_core #(
  parameter int DEPTH = 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire vjb_pkg::item_t  item,
  input  wire vjb_pkg::cfg_t   cfg,
  output vjb_pkg::result_t     result
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int W     = (SUM_W > 4) ? SUM_W : 4;
  localparam logic [DEPTH:0] ONES = '1;

  vjb_pkg::slot_t ent_r [DEPTH];
  vjb_pkg::slot_t ent_nxt [DEPTH];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic primed_r, primed_nxt;
  logic [vjb_pkg::SEQ_W-1:0] exp_r, exp_nxt;

  vjb_pkg::slot_t new_slot;
  vjb_pkg::slot_t merged [DEPTH+1];
  vjb_pkg::slot_t sh [DEPTH];
  logic [DEPTH:0] p;
  logic [DEPTH-1:0] le;
  logic [vjb_pkg::SEQ_W-1:0] diff;
  logic [W-1:0] new_cnt, capc, drop_w, fill_w, cnt_w;
  logic tick_on, hit;

  always_comb begin
    new_slot.seq = item.seq;
    new_slot.tag = item.tag;
    new_slot.ok  = item.ok;

    // insert point: first held entry that the new frame strictly precedes
    for (int i = 0; i < DEPTH; i++) begin
      diff = item.seq - ent_r[i].seq;
      if (W'(i) < W'(count_r)) begin
        p[i] = diff[vjb_pkg::SEQ_W-1];
      end else begin
        p[i] = 1'b1;
      end
    end
    p[DEPTH] = 1'b1;
    for (int j = 0; j < DEPTH; j++) begin
      le[j] = |(p & (ONES >> (DEPTH - j)));
    end

    merged[0] = le[0] ? new_slot : ent_r[0];
    for (int j = 1; j < DEPTH; j++) begin
      if (!le[j]) begin
        merged[j] = ent_r[j];
      end else if (le[j-1]) begin
        merged[j] = ent_r[j-1];
      end else begin
        merged[j] = new_slot;
      end
    end
    merged[DEPTH] = le[DEPTH-1] ? ent_r[DEPTH-1] : new_slot;

    new_cnt = W'(count_r) + W'(1);
    if (cfg.cap == 4'd0) begin
      capc = W'(1);
    end else if (W'(cfg.cap) > W'(DEPTH)) begin
      capc = W'(DEPTH);
    end else begin
      capc = W'(cfg.cap);
    end
    drop_w = (new_cnt > capc) ? (new_cnt - capc) : '0;
    fill_w = new_cnt - drop_w;

    // drop the oldest frames beyond the cap
    for (int k = 0; k < DEPTH; k++) begin
      sh[k] = merged[k];
      for (int d = 1; d <= DEPTH; d++) begin
        if ((k + d <= DEPTH) && (drop_w == W'(d))) begin
          sh[k] = merged[(k + d <= DEPTH) ? (k + d) : DEPTH];
        end
      end
    end

    tick_on = primed_r && !cfg.muted && (count_r != '0);
    hit     = (ent_r[0].seq == exp_r);

    ent_nxt    = ent_r;
    count_nxt  = count_r;
    primed_nxt = primed_r;
    exp_nxt    = exp_r;
    result     = '0;

    if (item.mode == vjb_pkg::MODE_SUBMIT) begin
      ent_nxt   = sh;
      count_nxt = CNT_W'(fill_w);
      if (!primed_r && (fill_w >= W'(cfg.target))) begin
        primed_nxt = 1'b1;
        exp_nxt    = sh[0].seq;
      end
      result.status  = vjb_pkg::ST_STORED;
      result.dropped = (drop_w > W'(15)) ? 4'd15 : drop_w[3:0];
    end else if (tick_on) begin
      if (hit) begin
        for (int k = 0; k < DEPTH - 1; k++) begin
          ent_nxt[k] = ent_r[k+1];
        end
        count_nxt     = count_r - CNT_W'(1);
        result.status = vjb_pkg::ST_PLAYED;
        result.seq    = ent_r[0].seq;
        result.tag    = ent_r[0].tag;
        result.ok     = ent_r[0].ok;
      end else begin
        result.status = vjb_pkg::ST_LOST;
        result.seq    = exp_r;
        result.ok     = 1'b1;
      end
      exp_nxt = exp_r + vjb_pkg::SEQ_W'(1);
      if (count_nxt == '0) begin
        primed_nxt = 1'b0;
      end
    end else begin
      result.status = vjb_pkg::ST_IDLE;
    end

    cnt_w         = W'(count_nxt);
    result.fill   = (cnt_w > W'(15)) ? 4'd15 : cnt_w[3:0];
    result.primed = primed_nxt;
  end

  always_ff @(posedge clk) begin
    if (step) begin
      ent_r <= ent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      primed_r <= 1'b0;
      exp_r    <= '0;
    end else if (step) begin
      count_r  <= count_nxt;
      primed_r <= primed_nxt;
      exp_r    <= exp_nxt;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    W'(count_r) <= W'(DEPTH))
    else $error("frame count above depth");

  a_primed_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    primed_r |-> (count_r != '0))
    else $error("primed with an empty list");

  a_play_pops: assert property (@(posedge clk) disable iff (!rst_n)
    (step && item.mode == vjb_pkg::MODE_TICK && tick_on && hit)
      |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("played frame not removed");
`endif

endmodule

`default_nettype wire

[hw/rtl/voice_jitter_buffer.sv]
// top level of the voice jitter buffer: stream ports, config registers,
// input and result registers; depends on vjb_pkg and vjb_core
//
// channel | role             | handshake         | payload
// in_     | submit / tick    | tvalid, tready    | tdata 40b, tuser 1b
// out_    | one result each  | tvalid, tready    | tdata 48b, tuser 2b
// cfg_    | register access  | psel, penable     | 32b data, 4b address
//
// one item per cycle sustained unless the result is stalled; out_tvalid rises after the input transfer
// (input register, then result register around one pass of the list logic)
// reset clears count, priming and expected sequence; frame slots are not cleared
// a stalled result holds the result register and then the input register
`timescale 1ns / 1ps
`default_nettype none

module voice_jitter_buffer #(
  parameter int DEPTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // sequence_req [15:0], frame_tag [31:16], frame_ok [32], zero fill
  input  wire logic [39:0] in_tdata,
  // mode [0]
  input  wire logic [0:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // dropped_count [3:0], out_sequence [19:4], out_tag [35:20], out_ok [36],
  // fill [40:37], is_primed [41], zero fill
  output logic [47:0]      out_tdata,
  // status [1:0]
  output logic [1:0]       out_tuser,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  vjb_pkg::cfg_t    cfg_r;
  vjb_pkg::item_t   in_item_r;
  vjb_pkg::result_t res, out_res_r;
  logic in_v_r, out_v_r, step, cfg_wr;

  assign step      = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || step;
  assign cfg_pready = 1'b1;
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target <= vjb_pkg::TARGET_RST;
      cfg_r.cap    <= vjb_pkg::CAP_RST;
      cfg_r.muted  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        vjb_pkg::REG_TARGET: cfg_r.target <= cfg_pwdata[3:0];
        vjb_pkg::REG_CAP:    cfg_r.cap    <= cfg_pwdata[3:0];
        vjb_pkg::REG_MUTED:  cfg_r.muted  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      vjb_pkg::REG_TARGET: cfg_prdata = {28'd0, cfg_r.target};
      vjb_pkg::REG_CAP:    cfg_prdata = {28'd0, cfg_r.cap};
      vjb_pkg::REG_MUTED:  cfg_prdata = {31'd0, cfg_r.muted};
      default:             cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.mode <= in_tuser[0];
      in_item_r.seq  <= in_tdata[15:0];
      in_item_r.tag  <= in_tdata[31:16];
      in_item_r.ok   <= in_tdata[32];
    end
  end

  vjb_core #(
    .DEPTH(DEPTH)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (in_item_r),
    .cfg    (cfg_r),
    .result (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {6'd0, out_res_r.primed, out_res_r.fill, out_res_r.ok,
                       out_res_r.tag, out_res_r.seq, out_res_r.dropped};

`ifndef SYNTHESIS
  a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_v_r)
    else $error("processed item left no result");

  a_held_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !step) |=> (in_v_r && $stable(in_item_r)))
    else $error("waiting item lost or changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> in_tready)
    else $error("input stalled with an empty result register");
`endif

endmodule

`default_nettype wire

[bench/voice_jitter_buffer_tb.sv]
// self-checking bench for voice_jitter_buffer: directed cases, then random submit/tick streams
// a local model of the sorted frame list predicts every result; depends on vjb_pkg and the rtl
`timescale 1ns / 1ps

module voice_jitter_buffer_tb;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  voice_jitter_buffer dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #6 clk = ~clk;

  // model of the frame list
  logic [15:0] list_seq [0:8];
  logic [15:0] list_tag [0:8];
  logic        list_ok  [0:8];
  int          held = 0;
  bit          primed = 1'b0;
  logic [15:0] next_play = '0;
  logic [3:0]  cfg_target = vjb_pkg::TARGET_RST;
  logic [3:0]  cfg_cap = vjb_pkg::CAP_RST;
  bit          cfg_muted = 1'b0;

  // ring of predicted results still in flight
  vjb_pkg::result_t exp_ring [16];
  logic [3:0]       exp_wr_idx = '0;
  logic [3:0]       exp_rd_idx = '0;
  int               exp_pending = 0;
  int               errors = 0;
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;

  function automatic void pop_head_frame();
    for (int i = 0; i < held - 1; i++) begin
      list_seq[i] = list_seq[i+1];
      list_tag[i] = list_tag[i+1];
      list_ok[i]  = list_ok[i+1];
    end
    held--;
  endfunction

  function automatic vjb_pkg::result_t buffer_step(logic mode, logic [15:0] seq,
                                                   logic [15:0] tag, logic ok);
    vjb_pkg::result_t r;
    int               pos;
    int               lim;
    int               nd;
    logic [15:0]      diff;
    r = '0;
    if (mode == vjb_pkg::MODE_SUBMIT) begin
      pos = held;
      for (int i = 0; i < held; i++) begin
        diff = seq - list_seq[i];
        if (pos == held && diff[15]) pos = i;
      end
      for (int i = held; i > pos; i--) begin
        list_seq[i] = list_seq[i-1];
        list_tag[i] = list_tag[i-1];
        list_ok[i]  = list_ok[i-1];
      end
      list_seq[pos] = seq;
      list_tag[pos] = tag;
      list_ok[pos]  = ok;
      held++;
      lim = (cfg_cap == 0) ? 1 : ((cfg_cap > 8) ? 8 : int'(cfg_cap));
      nd = 0;
      while (held > lim) begin
        pop_head_frame();
        nd++;
      end
      if (!primed && held >= int'(cfg_target)) begin
        primed = 1'b1;
        next_play = list_seq[0];
      end
      r.status = vjb_pkg::ST_STORED;
      r.dropped = 4'(nd);
    end else if (primed && !cfg_muted && held > 0) begin
      if (list_seq[0] == next_play) begin
        r.status = vjb_pkg::ST_PLAYED;
        r.seq = list_seq[0];
        r.tag = list_tag[0];
        r.ok = list_ok[0];
        pop_head_frame();
      end else begin
        r.status = vjb_pkg::ST_LOST;
        r.seq = next_play;
        r.ok = 1'b1;
      end
      next_play = next_play + 16'd1;
      if (held == 0) primed = 1'b0;
    end else begin
      r.status = vjb_pkg::ST_IDLE;
    end
    r.fill = 4'(held);
    r.primed = primed;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= 40) $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // result side: random stall and compare against the oldest prediction
  always @(posedge clk) begin
    vjb_pkg::result_t want;
    vjb_pkg::result_t got;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      got.status  = out_tuser;
      got.dropped = out_tdata[3:0];
      got.seq     = out_tdata[19:4];
      got.tag     = out_tdata[35:20];
      got.ok      = out_tdata[36];
      got.fill    = out_tdata[40:37];
      got.primed  = out_tdata[41];
      if (exp_pending == 0) begin
        report_mismatch("result transfer with nothing pending");
      end else begin
        want = exp_ring[exp_rd_idx];
        exp_rd_idx = exp_rd_idx + 4'd1;
        exp_pending--;
        check_field("status", 16'(got.status), 16'(want.status));
        check_field("dropped_count", 16'(got.dropped), 16'(want.dropped));
        check_field("out_sequence", got.seq, want.seq);
        check_field("out_tag", got.tag, want.tag);
        check_field("out_ok", 16'(got.ok), 16'(want.ok));
        check_field("fill", 16'(got.fill), 16'(want.fill));
        check_field("is_primed", 16'(got.primed), 16'(want.primed));
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_item(logic mode, logic [15:0] seq, logic [15:0] tag, logic ok);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {7'b0, ok, tag, seq};
    do @(posedge clk); while (!in_tready);
    exp_ring[exp_wr_idx] = buffer_step(mode, seq, tag, ok);
    exp_wr_idx = exp_wr_idx + 4'd1;
    exp_pending++;
  endtask

  task automatic wait_results_done();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (exp_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [3:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {28'b0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      vjb_pkg::REG_TARGET: cfg_target = val;
      vjb_pkg::REG_CAP:    cfg_cap = val;
      vjb_pkg::REG_MUTED:  cfg_muted = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic test_unprimed_tick();
    send_item(vjb_pkg::MODE_TICK, 16'hffff, 16'hffff, 1'b1);
  endtask

  // head ordering across the sequence wrap, play until empty
  task automatic test_wrap_play();
    send_item(vjb_pkg::MODE_SUBMIT, 16'hfffe, 16'hffff, 1'b0);
    send_item(vjb_pkg::MODE_SUBMIT, 16'h0000, 16'h0000, 1'b1);
    send_item(vjb_pkg::MODE_SUBMIT, 16'hffff, 16'h1234, 1'b1);
    repeat (4) send_item(vjb_pkg::MODE_TICK, 16'h0000, 16'h0000, 1'b0);
  endtask

  // equal sequences, then a head that no longer matches
  task automatic test_loss_stale_head();
    wait_results_done();
    write_reg(vjb_pkg::REG_TARGET, 4'd2);
    send_item(vjb_pkg::MODE_SUBMIT, 16'd10, 16'haaaa, 1'b1);
    send_item(vjb_pkg::MODE_SUBMIT, 16'd10, 16'h5555, 1'b0);
    repeat (3) send_item(vjb_pkg::MODE_TICK, 16'h0000, 16'h0000, 1'b0);
  endtask

  task automatic test_cap_drop();
    wait_results_done();
    write_reg(vjb_pkg::REG_CAP, 4'd2);
    send_item(vjb_pkg::MODE_SUBMIT, 16'd13, 16'h0013, 1'b1);
    send_item(vjb_pkg::MODE_SUBMIT, 16'd14, 16'h0014, 1'b1);
    wait_results_done();
    write_reg(vjb_pkg::REG_CAP, 4'd1);
    send_item(vjb_pkg::MODE_SUBMIT, 16'd15, 16'h0015, 1'b1);
    wait_results_done();
    write_reg(vjb_pkg::REG_CAP, 4'd0);
    send_item(vjb_pkg::MODE_SUBMIT, 16'd7, 16'h0007, 1'b0);
  endtask

  task automatic test_mute();
    wait_results_done();
    write_reg(vjb_pkg::REG_MUTED, 4'd1);
    send_item(vjb_pkg::MODE_TICK, 16'h0000, 16'h0000, 1'b0);
    wait_results_done();
    write_reg(vjb_pkg::REG_MUTED, 4'd0);
    send_item(vjb_pkg::MODE_TICK, 16'h0000, 16'h0000, 1'b0);
  endtask

  task automatic test_target_extremes();
    while (primed) send_item(vjb_pkg::MODE_TICK, 16'h0000, 16'h0000, 1'b0);
    wait_results_done();
    write_reg(vjb_pkg::REG_TARGET, 4'd0);
    write_reg(vjb_pkg::REG_CAP, 4'd15);
    send_item(vjb_pkg::MODE_SUBMIT, 16'd100, 16'h0100, 1'b1);
    send_item(vjb_pkg::MODE_TICK, 16'h0000, 16'h0000, 1'b0);
    wait_results_done();
    write_reg(vjb_pkg::REG_TARGET, 4'd15);
    send_item(vjb_pkg::MODE_SUBMIT, 16'd200, 16'h0200, 1'b1);
    send_item(vjb_pkg::MODE_TICK, 16'h0000, 16'h0000, 1'b0);
  endtask

  // mostly in-order frames with reorder, gaps and late copies; some noise
  task automatic test_random_stream(logic [3:0] target, logic [3:0] cap, int send_pct,
                                    int recv_pct, int items);
    logic [15:0] flow_seq;
    logic [15:0] s;
    int          k;
    wait_results_done();
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    write_reg(vjb_pkg::REG_TARGET, target);
    write_reg(vjb_pkg::REG_CAP, cap);
    flow_seq = ($urandom_range(3) == 0) ? 16'hfff8 + 16'($urandom_range(7)) : 16'($urandom);
    for (int n = 0; n < items; n++) begin
      if (n % 52 == 0) begin
        wait_results_done();
        write_reg(vjb_pkg::REG_MUTED, ($urandom_range(5) == 0) ? 4'd1 : 4'd0);
      end
      k = $urandom_range(99);
      if (k < 46) begin
        send_item(vjb_pkg::MODE_TICK, 16'($urandom), 16'($urandom), 1'($urandom));
      end else if (k < 92) begin
        k = $urandom_range(15);
        if (k < 10) begin
          s = flow_seq;
          flow_seq = flow_seq + 16'd1;
        end else if (k < 12) begin
          s = flow_seq + 16'd1;
        end else if (k < 14) begin
          s = flow_seq + 16'd1;
          flow_seq = flow_seq + 16'd2;
        end else begin
          s = flow_seq - 16'd1 - 16'($urandom_range(3));
        end
        send_item(vjb_pkg::MODE_SUBMIT, s, 16'($urandom), $urandom_range(4) != 0);
      end else begin
        send_item(vjb_pkg::MODE_SUBMIT, 16'($urandom), 16'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_unprimed_tick();
    test_wrap_play();
    test_loss_stale_head();
    test_cap_drop();
    test_mute();
    test_target_extremes();
    test_random_stream(4'd3, 4'd8, 0, 0, 206);
    test_random_stream(4'd1, 4'd8, 52, 0, 206);
    test_random_stream(4'd8, 4'd8, 0, 52, 206);
    test_random_stream(4'd2, 4'd3, 29, 29, 206);
    test_random_stream(4'd0, 4'd15, 0, 0, 206);
    test_random_stream(4'd1, 4'd1, 52, 0, 206);
    test_random_stream(4'd6, 4'd7, 0, 52, 206);
    test_random_stream(4'($urandom_range(1, 4)), 4'($urandom_range(4, 8)), 29, 29, 206);
    wait_results_done();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
